### sv/desr_pkg.sv
// shared types, bit-selection tables and s-box contents for the des round pipeline
// no dependencies; used by every desr_* stage and by des_feistel_round
package desr_pkg;

   typedef logic [63:0] block_type;
   typedef logic [47:0] exp_type;
   typedef logic [31:0] half_type;
   typedef logic [5:0]  six_type;
   typedef logic [3:0]  nib_type;

   localparam int unsigned NumSbox = 8;
   localparam int unsigned ExpBits = 48;
   localparam int unsigned HalfBits = 32;

   // standard numbering: entry i names the source bit, 1 is the msb
   localparam int unsigned EXP_SEL [0:47] = '{
      32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9,
      8, 9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
      16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
      24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1
   };

   localparam int unsigned PERM_SEL [0:31] = '{
      16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
      2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
   };

   // index is row * 16 + column
   localparam nib_type SBOX_TAB [0:7][0:63] = '{
      '{14, 4, 13, 1, 2, 15, 11, 8, 3, 10, 6, 12, 5, 9, 0, 7,
        0, 15, 7, 4, 14, 2, 13, 1, 10, 6, 12, 11, 9, 5, 3, 8,
        4, 1, 14, 8, 13, 6, 2, 11, 15, 12, 9, 7, 3, 10, 5, 0,
        15, 12, 8, 2, 4, 9, 1, 7, 5, 11, 3, 14, 10, 0, 6, 13},
      '{15, 1, 8, 14, 6, 11, 3, 4, 9, 7, 2, 13, 12, 0, 5, 10,
        3, 13, 4, 7, 15, 2, 8, 14, 12, 0, 1, 10, 6, 9, 11, 5,
        0, 14, 7, 11, 10, 4, 13, 1, 5, 8, 12, 6, 9, 3, 2, 15,
        13, 8, 10, 1, 3, 15, 4, 2, 11, 6, 7, 12, 0, 5, 14, 9},
      '{10, 0, 9, 14, 6, 3, 15, 5, 1, 13, 12, 7, 11, 4, 2, 8,
        13, 7, 0, 9, 3, 4, 6, 10, 2, 8, 5, 14, 12, 11, 15, 1,
        13, 6, 4, 9, 8, 15, 3, 0, 11, 1, 2, 12, 5, 10, 14, 7,
        1, 10, 13, 0, 6, 9, 8, 7, 4, 15, 14, 3, 11, 5, 2, 12},
      '{7, 13, 14, 3, 0, 6, 9, 10, 1, 2, 8, 5, 11, 12, 4, 15,
        13, 8, 11, 5, 6, 15, 0, 3, 4, 7, 2, 12, 1, 10, 14, 9,
        10, 6, 9, 0, 12, 11, 7, 13, 15, 1, 3, 14, 5, 2, 8, 4,
        3, 15, 0, 6, 10, 1, 13, 8, 9, 4, 5, 11, 12, 7, 2, 14},
      '{2, 12, 4, 1, 7, 10, 11, 6, 8, 5, 3, 15, 13, 0, 14, 9,
        14, 11, 2, 12, 4, 7, 13, 1, 5, 0, 15, 10, 3, 9, 8, 6,
        4, 2, 1, 11, 10, 13, 7, 8, 15, 9, 12, 5, 6, 3, 0, 14,
        11, 8, 12, 7, 1, 14, 2, 13, 6, 15, 0, 9, 10, 4, 5, 3},
      '{12, 1, 10, 15, 9, 2, 6, 8, 0, 13, 3, 4, 14, 7, 5, 11,
        10, 15, 4, 2, 7, 12, 9, 5, 6, 1, 13, 14, 0, 11, 3, 8,
        9, 14, 15, 5, 2, 8, 12, 3, 7, 0, 4, 10, 1, 13, 11, 6,
        4, 3, 2, 12, 9, 5, 15, 10, 11, 14, 1, 7, 6, 0, 8, 13},
      '{4, 11, 2, 14, 15, 0, 8, 13, 3, 12, 9, 7, 5, 10, 6, 1,
        13, 0, 11, 7, 4, 9, 1, 10, 14, 3, 5, 12, 2, 15, 8, 6,
        1, 4, 11, 13, 12, 3, 7, 14, 10, 15, 6, 8, 0, 5, 9, 2,
        6, 11, 13, 8, 1, 4, 10, 7, 9, 5, 0, 15, 14, 2, 3, 12},
      '{13, 2, 8, 4, 6, 15, 11, 1, 10, 9, 3, 14, 5, 0, 12, 7,
        1, 15, 13, 8, 10, 3, 7, 4, 12, 5, 6, 11, 0, 14, 9, 2,
        7, 11, 4, 1, 9, 12, 14, 2, 0, 6, 10, 13, 15, 3, 5, 8,
        2, 1, 14, 7, 4, 10, 8, 13, 15, 12, 9, 0, 3, 5, 6, 11}
   };

   // e expansion of the right half
   function automatic exp_type expand(input half_type r);
      exp_type e;
      e = '0;
      for (int i = 0; i < ExpBits; i++) begin
         e[ExpBits - 1 - i] = r[5'(HalfBits - EXP_SEL[i])];
      end
      return e;
   endfunction

   // eight s-boxes; outer bits pick the row, middle four the column
   function automatic half_type sbox_all(input exp_type x);
      half_type s;
      six_type  six;
      s   = '0;
      six = '0;
      for (int i = 0; i < NumSbox; i++) begin
         six = x[ExpBits - 1 - 6 * i -: 6];
         s[HalfBits - 1 - 4 * i -: 4] = SBOX_TAB[i][{six[5], six[0], six[4:1]}];
      end
      return s;
   endfunction

   // p permutation
   function automatic half_type permute(input half_type s);
      half_type f;
      f = '0;
      for (int i = 0; i < HalfBits; i++) begin
         f[HalfBits - 1 - i] = s[5'(HalfBits - PERM_SEL[i])];
      end
      return f;
   endfunction

endpackage

### sv/desr_expand.sv
// stage 1 of the round pipeline: e expansion of the right half xor round key
// depends on desr_pkg
module desr_expand (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  desr_pkg::block_type in_block,
   input  desr_pkg::exp_type  in_key,
   output logic               out_valid,
   input  logic               out_ready,
   output desr_pkg::half_type out_left,
   output desr_pkg::half_type out_right,
   output desr_pkg::exp_type  out_x
);
   import desr_pkg::*;

   logic     valid_ff;
   half_type left_ff;
   half_type right_ff;
   exp_type  x_ff;
   exp_type  x_in;

   assign in_ready = !valid_ff || out_ready;
   assign x_in     = expand(in_block[31:0]) ^ in_key;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         left_ff  <= in_block[63:32];
         right_ff <= in_block[31:0];
         x_ff     <= x_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_left  = left_ff;
   assign out_right = right_ff;
   assign out_x     = x_ff;

endmodule

### sv/desr_sbox.sv
// stage 2 of the round pipeline: s-box substitution s1..s8
// depends on desr_pkg
module desr_sbox (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  desr_pkg::half_type in_left,
   input  desr_pkg::half_type in_right,
   input  desr_pkg::exp_type  in_x,
   output logic               out_valid,
   input  logic               out_ready,
   output desr_pkg::half_type out_left,
   output desr_pkg::half_type out_right,
   output desr_pkg::half_type out_s
);
   import desr_pkg::*;

   logic     valid_ff;
   half_type left_ff;
   half_type right_ff;
   half_type s_ff;
   half_type s_in;

   assign in_ready = !valid_ff || out_ready;
   assign s_in     = sbox_all(in_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         left_ff  <= in_left;
         right_ff <= in_right;
         s_ff     <= s_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_left  = left_ff;
   assign out_right = right_ff;
   assign out_s     = s_ff;

endmodule

### sv/desr_permute.sv
// stage 3 of the round pipeline: p permutation, xor into left, swap halves
// depends on desr_pkg; its register is the output register of the block
module desr_permute (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  desr_pkg::half_type  in_left,
   input  desr_pkg::half_type  in_right,
   input  desr_pkg::half_type  in_s,
   output logic                out_valid,
   input  logic                out_ready,
   output desr_pkg::block_type out_block
);
   import desr_pkg::*;

   logic      valid_ff;
   block_type block_ff;
   block_type block_in;

   assign in_ready = !valid_ff || out_ready;
   assign block_in = {in_right, in_left ^ permute(in_s)};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         block_ff <= block_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_block = block_ff;

endmodule

### sv/des_feistel_round.sv
// top level: one des feistel round as a three-stage valid/ready pipeline
// depends on desr_pkg, desr_expand, desr_sbox, desr_permute
//
//   port group   dir   width  content
//   req_*        in    64+48  block_in (left half on top), round_key
//   rsp_*        out   64     block_out: old right half, then left xor f
//
// rsp_valid rises once a request has passed the stage registers (expand/xor,
// s-box, permute/xor) in turn; one request per cycle is taken in steady state
// while rsp_ready stays high
// each stage holds its data while the next one is full and not ready, and a
// bubble anywhere lets a new request in even while a result waits
// synchronous reset clears only the stage valid bits
module des_feistel_round (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  desr_pkg::block_type req_block_in,
   input  desr_pkg::exp_type   req_round_key,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output desr_pkg::block_type rsp_block_out
);
   import desr_pkg::*;

   logic     s1_valid;
   logic     s1_ready;
   half_type s1_left;
   half_type s1_right;
   exp_type  s1_x;
   logic     s2_valid;
   logic     s2_ready;
   half_type s2_left;
   half_type s2_right;
   half_type s2_s;

   desr_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_block  (req_block_in),
      .in_key    (req_round_key),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_left  (s1_left),
      .out_right (s1_right),
      .out_x     (s1_x)
   );

   desr_sbox u_sbox (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_left   (s1_left),
      .in_right  (s1_right),
      .in_x      (s1_x),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_left  (s2_left),
      .out_right (s2_right),
      .out_s     (s2_s)
   );

   desr_permute u_permute (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_left   (s2_left),
      .in_right  (s2_right),
      .in_s      (s2_s),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_block (rsp_block_out)
   );

   // back-pressure only when every stage is full
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid && s2_valid && rsp_valid && !rsp_ready))
      else $error("request blocked with a bubble in the pipeline");

   // a request in stage 1 that is not held must show up in stage 2
   a_s1_advances: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && s1_ready) |=> s2_valid)
      else $error("stage 1 request lost");

   // accepted request lands in stage 1 with its right half intact
   a_s1_capture: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (s1_valid && s1_right == $past(req_block_in[31:0])))
      else $error("stage 1 capture mismatch");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !s1_valid && !s2_valid))
      else $error("pipeline not empty after reset");

endmodule

### bench/des_feistel_round_chk.sv
// checker for des_feistel_round: watches both channels, predicts each round and compares
// depends on desr_pkg for the port types only; the round itself is computed here
`timescale 1ns / 100ps

module des_feistel_round_chk (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  desr_pkg::block_type req_block_in,
   input  desr_pkg::exp_type   req_round_key,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  desr_pkg::block_type rsp_block_out,
   output int unsigned         err_count,
   output int unsigned         pending,
   output int unsigned         checked_count
);
   import desr_pkg::*;

   // s-box rows, four per box, column c is the nibble at bits 63-4c
   localparam logic [63:0] SBOX_ROWS [0:31] = '{
      64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538, 64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D,
      64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5, 64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9,
      64'hA09E63F51DC7B428, 64'hD709346A285ECBF1, 64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C,
      64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9, 64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E,
      64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986, 64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453,
      64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38, 64'h9EF528C3704A1DB6, 64'h432C95FABE17608D,
      64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86, 64'h14BDC37EAF680592, 64'h6BD814A7950FE23C,
      64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92, 64'h7B419CE206ADF358, 64'h21E74A8DFC90356B
   };

   // p: output bit i (1 is the msb) takes s-box bit P_SRC[i]
   localparam int unsigned P_SRC [0:31] = '{
      16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
      2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
   };

   block_type   round_out_q [$];
   int unsigned n_err = 0;
   int unsigned n_pending = 0;
   int unsigned n_checked = 0;

   assign err_count     = n_err;
   assign pending       = n_pending;
   assign checked_count = n_checked;

   function automatic block_type feistel_round(input block_type blk, input exp_type key);
      half_type    l_half;
      half_type    r_half;
      half_type    s_out;
      half_type    f_out;
      logic [33:0] wrap;
      logic [5:0]  six;
      logic [63:0] srow;
      l_half = blk[63:32];
      r_half = blk[31:0];
      // e expansion: group g takes standard bits 4g..4g+5, wrapping 0 to 32 and 33 to 1
      wrap  = {r_half[0], r_half, r_half[31]};
      s_out = '0;
      for (int g = 0; g < 8; g++) begin
         six  = wrap[33 - 4 * g -: 6] ^ key[47 - 6 * g -: 6];
         srow = SBOX_ROWS[4 * g + int'({six[5], six[0]})];
         s_out[31 - 4 * g -: 4] = srow[63 - 4 * int'(six[4:1]) -: 4];
      end
      f_out = '0;
      for (int i = 0; i < 32; i++) begin
         f_out[31 - i] = s_out[32 - P_SRC[i]];
      end
      return {r_half, l_half ^ f_out};
   endfunction

   task automatic report_mismatch(input string what, input block_type got, input block_type want);
      n_err++;
      $display("%0t: mismatch %0d: %s, block_out got %h want %h", $realtime, n_err, what, got,
               want);
   endtask

   always @(posedge clock) begin
      block_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            round_out_q.push_back(feistel_round(req_block_in, req_round_key));
         end
         if (rsp_valid && rsp_ready) begin
            if (round_out_q.size() == 0) begin
               report_mismatch("result with no request outstanding", rsp_block_out, '0);
            end else begin
               want = round_out_q.pop_front();
               n_checked++;
               if (rsp_block_out !== want) begin
                  report_mismatch("wrong round output", rsp_block_out, want);
               end
            end
         end
         n_pending = round_out_q.size();
      end
   end

endmodule

### bench/tb_des_feistel_round.sv
// top of the des_feistel_round bench: clock, reset, request and response pacing, verdict
// depends on desr_pkg, des_feistel_round and des_feistel_round_chk
`timescale 1ns / 100ps

module tb_des_feistel_round;
   import desr_pkg::*;

   localparam int unsigned NumDirected = 14;
   localparam int unsigned RandCount   = 600;
   localparam int unsigned CalmFrom    = NumDirected + RandCount - 100;
   localparam int unsigned HoldAt      = 150;
   localparam int unsigned LongHold    = 120;
   localparam int unsigned StallLimit  = 1000;
   localparam int unsigned DrainCycles = 12;

   localparam block_type DIR_BLK [0:NumDirected-1] = '{
      64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF,
      64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 64'h0000000000000000, 64'h0000000000000000,
      64'h00000000FFFFFFFF, 64'hCC00CCFFF0AAF0AA, 64'hFFFFFFFF00000000, 64'h0000000100000001,
      64'h8000000080000000, 64'h0123456789ABCDEF
   };
   // s-box inputs all zero, all one, outer-only and middle-only among these
   localparam exp_type DIR_KEY [0:NumDirected-1] = '{
      48'h000000000000, 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 48'h000000000000,
      48'h555555555555, 48'hAAAAAAAAAAAA, 48'h861861861861, 48'h79E79E79E79E,
      48'h861861861861, 48'h1B02EFFC7072, 48'h000000000000, 48'h000000000001,
      48'h800000000000, 48'h0F1E2D3C4B5A
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   block_type   req_block_in;
   exp_type     req_round_key;
   logic        rsp_valid;
   logic        rsp_ready;
   block_type   rsp_block_out;

   int unsigned err_count;
   int unsigned pending;
   int unsigned checked_count;
   int unsigned accepted_count = 0;
   int unsigned stall_cycles = 0;

   always #2 clock = ~clock;

   des_feistel_round i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_block_in  (req_block_in),
      .req_round_key (req_round_key),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_block_out (rsp_block_out)
   );

   des_feistel_round_chk i_chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_block_in  (req_block_in),
      .req_round_key (req_round_key),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_block_out (rsp_block_out),
      .err_count     (err_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   // response side: ready in random bursts, one long hold-off so the pipe backs up
   initial begin : rsp_side
      int unsigned n;
      bit          held;
      held      = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!held && accepted_count >= HoldAt) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LongHold) @(negedge clock);
         end else if (accepted_count >= CalmFrom || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            if (accepted_count >= CalmFrom) n = 1;
            else if ($urandom_range(0, 7) == 0) n = $urandom_range(20, 60);
            else n = $urandom_range(1, 8);
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= StallLimit) begin
            $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                     stall_cycles, pending);
            $display("tb_des_feistel_round: done, errors");
            $finish;
         end
      end
   end

   initial begin : req_side
      block_type   blk;
      exp_type     key;
      int unsigned pick;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_block_in  = '0;
      req_round_key = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NumDirected + RandCount; i++) begin
         if (i < NumDirected) begin
            blk = DIR_BLK[i];
            key = DIR_KEY[i];
         end else begin
            pick = $urandom_range(0, 9);
            blk  = {$urandom, $urandom};
            key  = 48'({$urandom, $urandom});
            if (pick == 7) begin
               key = $urandom_range(0, 1) ? '1 : '0;
            end else if (pick == 8) begin
               // sparse values so single bit paths through e and p get isolated
               blk = 64'd1 << $urandom_range(0, 63);
               key = 48'd1 << $urandom_range(0, 47);
            end else if (pick == 9) begin
               blk[63:32] = $urandom_range(0, 1) ? '1 : '0;
            end
         end

         req_valid     <= 1'b1;
         req_block_in  <= blk;
         req_round_key <= key;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         accepted_count++;
         @(negedge clock);

         // request gaps, skipped in every third stretch of 40 and at the end
         if (accepted_count < CalmFrom && (accepted_count / 40) % 3 != 2
             && $urandom_range(0, 2) == 0) begin
            req_valid     <= 1'b0;
            req_block_in  <= {$urandom, $urandom};
            req_round_key <= 48'({$urandom, $urandom});
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("sent %0d round requests (%0d directed, %0d random), checked %0d results,",
               accepted_count, NumDirected, RandCount, checked_count);
      $display("with random gaps on both sides and one %0d-cycle output hold-off", LongHold);
      if (err_count == 0 && pending == 0) begin
         $display("tb_des_feistel_round: done, clean");
      end else begin
         $display("tb_des_feistel_round: done, errors");
      end
      $finish;
   end

endmodule

### sim.f
sv/desr_pkg.sv
sv/desr_expand.sv
sv/desr_sbox.sv
sv/desr_permute.sv
sv/des_feistel_round.sv
bench/des_feistel_round_chk.sv
bench/tb_des_feistel_round.sv
